>>> rtl/core/dsw_pkg.sv
// ----------------------------------------------------------------------------
// dsw_pkg: shared types and constants of the drive safety watchdog
// Holds the field widths, the func and register codes, and the structs that
// carry configuration, state, items and results between the modules.
// ----------------------------------------------------------------------------
package dsw_pkg;

  localparam int TIME_WIDTH = 32;
  localparam int ID_W       = 11;
  localparam int DATA_W     = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // func codes of an input item
  localparam logic [1:0] FUNC_TICK    = 2'd0;
  localparam logic [1:0] FUNC_VEHICLE = 2'd1;
  localparam logic [1:0] FUNC_INVERTER = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PEDAL_ID     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BATTERY_ID   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BATTERY_OK   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TRACTIVE_ID  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TRACTIVE_BIT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERTER_ID  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT      = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SOUND        = 3'd7;

  localparam logic [15:0] TIMEOUT_RESET = 16'd100;
  localparam logic [15:0] SOUND_RESET   = 16'd1000;

  typedef logic [TIME_WIDTH-1:0] time_t;

  // minimum tick gap between accepted pedal values, and the pedal upper limit
  localparam time_t             PEDAL_GAP   = TIME_WIDTH'(15);
  localparam logic signed [15:0] PEDAL_LIMIT = 16'sd500;

  typedef struct packed {
    logic [ID_W-1:0] pedal_frame_id;
    logic [ID_W-1:0] battery_frame_id;
    logic [7:0]      battery_ok_code;
    logic [ID_W-1:0] tractive_frame_id;
    logic [5:0]      tractive_bit_position;
    logic [ID_W-1:0] inverter_frame_id;
    logic [15:0]     timeout_ticks;
    logic [15:0]     sound_ticks;
  } cfg_t;

  typedef struct packed {
    time_t       tick_count;
    time_t       pedal_seen_time;
    time_t       pedal_accept_time;
    time_t       engine_seen_time;
    logic [15:0] pedal_store;
    logic        tractive_flag;
    logic        sound_flag;
    logic [15:0] sound_count;
    logic        stop_latch;
  } state_t;

  typedef struct packed {
    logic [1:0]        func;
    logic [ID_W-1:0]   frame_id;
    logic [DATA_W-1:0] data_bytes;
  } item_t;

  typedef struct packed {
    logic              stop_request;
    logic              stopped;
    logic signed [15:0] pedal_value;
    logic              tractive_on;
    logic              sound_on;
    logic              pedal_timeout;
    logic              engine_timeout;
    logic              inverter_valid;
    logic [7:0]        inverter_register;
    logic [15:0]       inverter_value;
  } result_t;

endpackage

>>> rtl/core/dsw_intf.sv
// ----------------------------------------------------------------------------
// dsw_in_if / dsw_out_if: valid/ready channels of the drive safety watchdog
// A beat moves when valid and ready are both high at a rising clock edge.
// ----------------------------------------------------------------------------
interface dsw_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    func;
  logic [dsw_pkg::ID_W-1:0]      frame_id;
  logic [dsw_pkg::DATA_W-1:0]    data_bytes;

  modport source (output valid, output func, output frame_id, output data_bytes,
                  input ready);
  modport sink   (input valid, input func, input frame_id, input data_bytes,
                  output ready);
endinterface

interface dsw_out_if;
  logic               valid;
  logic               ready;
  logic               stop_request;
  logic               stopped;
  logic signed [15:0] pedal_value;
  logic               tractive_on;
  logic               sound_on;
  logic               pedal_timeout;
  logic               engine_timeout;
  logic               inverter_valid;
  logic [7:0]         inverter_register;
  logic [15:0]        inverter_value;

  modport source (output valid, output stop_request, output stopped,
                  output pedal_value, output tractive_on, output sound_on,
                  output pedal_timeout, output engine_timeout,
                  output inverter_valid, output inverter_register,
                  output inverter_value, input ready);
  modport sink   (input valid, input stop_request, input stopped,
                  input pedal_value, input tractive_on, input sound_on,
                  input pedal_timeout, input engine_timeout,
                  input inverter_valid, input inverter_register,
                  input inverter_value, output ready);
endinterface

>>> rtl/core/dsw_cfg_regs.sv
// ----------------------------------------------------------------------------
// dsw_cfg_regs: configuration register file
// Write-only registers, one write per enabled clock edge, no read-back.
// ----------------------------------------------------------------------------
module dsw_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [dsw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dsw_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output dsw_pkg::cfg_t                  cfg
);

  dsw_pkg::cfg_t cfg_r;
  dsw_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        dsw_pkg::CFG_PEDAL_ID:     cfg_nxt.pedal_frame_id        = cfg_wdata[10:0];
        dsw_pkg::CFG_BATTERY_ID:   cfg_nxt.battery_frame_id      = cfg_wdata[10:0];
        dsw_pkg::CFG_BATTERY_OK:   cfg_nxt.battery_ok_code       = cfg_wdata[7:0];
        dsw_pkg::CFG_TRACTIVE_ID:  cfg_nxt.tractive_frame_id     = cfg_wdata[10:0];
        dsw_pkg::CFG_TRACTIVE_BIT: cfg_nxt.tractive_bit_position = cfg_wdata[5:0];
        dsw_pkg::CFG_INVERTER_ID:  cfg_nxt.inverter_frame_id     = cfg_wdata[10:0];
        dsw_pkg::CFG_TIMEOUT:      cfg_nxt.timeout_ticks         = cfg_wdata[15:0];
        dsw_pkg::CFG_SOUND:        cfg_nxt.sound_ticks           = cfg_wdata[15:0];
        default:                   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{pedal_frame_id:        '0,
                 battery_frame_id:      '0,
                 battery_ok_code:       '0,
                 tractive_frame_id:     '0,
                 tractive_bit_position: '0,
                 inverter_frame_id:     '0,
                 timeout_ticks:         dsw_pkg::TIMEOUT_RESET,
                 sound_ticks:           dsw_pkg::SOUND_RESET};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> rtl/core/dsw_update.sv
// ----------------------------------------------------------------------------
// dsw_update: single-pass state update of the watchdog
// Computes the next watchdog state and the result of one item.
// ----------------------------------------------------------------------------
module dsw_update (
  input  dsw_pkg::cfg_t    cfg,
  input  dsw_pkg::state_t  st,
  input  dsw_pkg::item_t   item,
  output dsw_pkg::state_t  st_nxt,
  output dsw_pkg::result_t res
);

  always_comb begin
    dsw_pkg::time_t     tick_new;
    dsw_pkg::time_t     ped_deadline;
    dsw_pkg::time_t     eng_deadline;
    dsw_pkg::time_t     gap_end;
    logic [15:0]        snd_cnt;
    logic               stop;
    logic               ped_to;
    logic               eng_to;
    logic               inv_ok;
    logic [7:0]         inv_reg;
    logic [15:0]        inv_val;

    st_nxt       = st;
    stop         = 1'b0;
    ped_to       = 1'b0;
    eng_to       = 1'b0;
    inv_ok       = 1'b0;
    inv_reg      = '0;
    inv_val      = '0;
    tick_new     = st.tick_count + dsw_pkg::time_t'(1);
    snd_cnt      = st.sound_count + 16'd1;
    ped_deadline = st.pedal_seen_time + dsw_pkg::time_t'(cfg.timeout_ticks);
    eng_deadline = st.engine_seen_time + dsw_pkg::time_t'(cfg.timeout_ticks);
    gap_end      = st.pedal_accept_time + dsw_pkg::PEDAL_GAP;

    case (item.func)
      dsw_pkg::FUNC_TICK: begin
        st_nxt.tick_count = tick_new;
        if (st.sound_flag) begin
          if (snd_cnt >= cfg.sound_ticks) begin
            st_nxt.sound_count = '0;
            st_nxt.sound_flag  = 1'b0;
          end else begin
            st_nxt.sound_count = snd_cnt;
          end
        end
        if (ped_deadline <= tick_new) begin
          ped_to = 1'b1;
          stop   = 1'b1;
        end
        eng_to = (eng_deadline <= tick_new);
      end
      dsw_pkg::FUNC_VEHICLE: begin
        // pedal id wins over battery, battery over tractive
        if (item.frame_id == cfg.pedal_frame_id) begin
          st_nxt.pedal_seen_time = st.tick_count;
          if (gap_end <= st.tick_count) begin
            st_nxt.pedal_accept_time = st.tick_count;
            if ($signed(item.data_bytes[15:0]) > dsw_pkg::PEDAL_LIMIT) begin
              stop               = 1'b1;
              st_nxt.pedal_store = '0;
            end else begin
              st_nxt.pedal_store = item.data_bytes[15:0];
            end
          end
        end else if (item.frame_id == cfg.battery_frame_id) begin
          stop = (item.data_bytes[31:24] != cfg.battery_ok_code);
        end else if (item.frame_id == cfg.tractive_frame_id) begin
          if (item.data_bytes[cfg.tractive_bit_position]) begin
            st_nxt.tractive_flag = 1'b1;
            st_nxt.sound_flag    = 1'b1;
            st_nxt.sound_count   = '0;
          end else begin
            st_nxt.tractive_flag = 1'b0;
          end
        end
      end
      dsw_pkg::FUNC_INVERTER: begin
        if (!st.stop_latch && item.frame_id == cfg.inverter_frame_id) begin
          st_nxt.engine_seen_time = st.tick_count;
          inv_ok  = 1'b1;
          inv_reg = item.data_bytes[7:0];
          inv_val = item.data_bytes[23:8];
        end
      end
      default: begin
        st_nxt = st;
      end
    endcase

    if (stop) begin
      st_nxt.stop_latch = 1'b1;
    end

    res.stop_request      = stop;
    res.stopped           = st_nxt.stop_latch;
    res.pedal_value       = $signed(st_nxt.pedal_store);
    res.tractive_on       = st_nxt.tractive_flag;
    res.sound_on          = st_nxt.sound_flag;
    res.pedal_timeout     = ped_to;
    res.engine_timeout    = eng_to;
    res.inverter_valid    = inv_ok;
    res.inverter_register = inv_reg;
    res.inverter_value    = inv_val;
  end

endmodule

>>> rtl/core/drive_safety_watchdog.sv
// ----------------------------------------------------------------------------
// drive_safety_watchdog: vehicle safety watchdog over ticks and bus frames
// Input register, one pass of update logic, result register.
// ----------------------------------------------------------------------------
// Path: an accepted input beat is held in the input register, passes the update
//   logic when the result register is free or drained, then sits in the result register.
// Throughput: one item per clock while the result channel is not stalled.
// Reset: synchronous, active low; clears the watchdog state and both valid
//   flags and loads the configuration reset values (timeout 100, sound 1000).
module drive_safety_watchdog (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [dsw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dsw_pkg::CFG_DATA_W-1:0] cfg_wdata,
  dsw_in_if.sink                         in_ch,
  dsw_out_if.source                      out_ch
);

  dsw_pkg::cfg_t    cfg;
  dsw_pkg::item_t   item_r;
  logic             item_v_r;
  logic             item_v_nxt;
  dsw_pkg::state_t  st_r;
  dsw_pkg::state_t  st_nxt;
  dsw_pkg::result_t upd_res;
  dsw_pkg::result_t res_r;
  logic             out_v_r;
  logic             out_v_nxt;
  logic             in_fire;
  logic             advance;

  // Configuration registers; user must write only while the block is idle (unenforced).
  dsw_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Advance the held item when the result register is free or being drained.
  assign advance  = item_v_r && (!out_v_r || out_ch.ready);
  // Take a new beat when the input register is empty or empties in the same
  // cycle, so beats can follow back to back.
  assign in_ch.ready = !item_v_r || advance;
  assign in_fire  = in_ch.valid && in_ch.ready;

  assign item_v_nxt = in_fire ? 1'b1 : (advance ? 1'b0 : item_v_r);
  assign out_v_nxt  = advance ? 1'b1 : (out_ch.ready ? 1'b0 : out_v_r);

  // One pass of the watchdog update on the registered item.
  dsw_update u_upd (
    .cfg    (cfg),
    .st     (st_r),
    .item   (item_r),
    .st_nxt (st_nxt),
    .res    (upd_res)
  );

  // Control state and watchdog state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
      out_v_r  <= 1'b0;
      st_r     <= '0;
    end else begin
      item_v_r <= item_v_nxt;
      out_v_r  <= out_v_nxt;
      if (advance) begin
        st_r <= st_nxt;
      end
    end
  end

  // Payload registers: load the input beat on accept, the result on advance.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r.func       <= in_ch.func;
      item_r.frame_id   <= in_ch.frame_id;
      item_r.data_bytes <= in_ch.data_bytes;
    end
    if (advance) begin
      res_r <= upd_res;
    end
  end

  // Drive the result channel straight from the result register.
  assign out_ch.valid             = out_v_r;
  assign out_ch.stop_request      = res_r.stop_request;
  assign out_ch.stopped           = res_r.stopped;
  assign out_ch.pedal_value       = res_r.pedal_value;
  assign out_ch.tractive_on       = res_r.tractive_on;
  assign out_ch.sound_on          = res_r.sound_on;
  assign out_ch.pedal_timeout     = res_r.pedal_timeout;
  assign out_ch.engine_timeout    = res_r.engine_timeout;
  assign out_ch.inverter_valid    = res_r.inverter_valid;
  assign out_ch.inverter_register = res_r.inverter_register;
  assign out_ch.inverter_value    = res_r.inverter_value;

endmodule

>>> rtl/core/dsw_checker.sv
// ----------------------------------------------------------------------------
// dsw_port_props: port-level assertions of the drive safety watchdog
// Watches the result channel over time and is bound to the top level.
// ----------------------------------------------------------------------------
module dsw_port_props (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        stop_request,
  input logic        stopped,
  input logic        pedal_timeout,
  input logic        inverter_valid,
  input logic [15:0] inverter_value
);

  logic seen_stop_r;
  logic seen_stop_nxt;

  // Remember that a delivered beat already showed the stop latch set.
  assign seen_stop_nxt = seen_stop_r || (out_valid && out_ready && stopped);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_stop_r <= 1'b0;
    end else begin
      seen_stop_r <= seen_stop_nxt;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(stopped) &&
    $stable(inverter_value))
    else $error("result beat changed while stalled");

  a_latch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && seen_stop_r |-> stopped)
    else $error("stop latch cleared after a stop");

  a_stop_sets_latch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && stop_request |-> stopped)
    else $error("stop request without stop latch");

  a_timeout_stops: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && pedal_timeout |-> stop_request)
    else $error("pedal timeout without stop request");

  a_inverter_live: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && inverter_valid |-> !stopped && !stop_request)
    else $error("inverter reply reported while stopped");

endmodule

bind drive_safety_watchdog dsw_port_props u_dsw_port_props (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .stop_request   (out_ch.stop_request),
  .stopped        (out_ch.stopped),
  .pedal_timeout  (out_ch.pedal_timeout),
  .inverter_valid (out_ch.inverter_valid),
  .inverter_value (out_ch.inverter_value)
);
